// ----- sv/bsfd_pkg.sv -----
// Shared types and constants for the byte stuffing frame decoder.
package bsfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic CmdPush  = 1'b0;
  localparam logic CmdReset = 1'b1;

  localparam logic [1:0] StatusIdle     = 2'd0;
  localparam logic [1:0] StatusBusy     = 2'd1;
  localparam logic [1:0] StatusComplete = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  localparam logic [1:0] RegDelimiter = 2'd0;
  localparam logic [1:0] RegEscape    = 2'd1;
  localparam logic [1:0] RegMask      = 2'd2;
  localparam logic [1:0] RegCapacity  = 2'd3;

  localparam logic [ByteW-1:0]  DelimiterReset = 8'd126;
  localparam logic [ByteW-1:0]  EscapeReset    = 8'd125;
  localparam logic [ByteW-1:0]  MaskReset      = 8'd32;
  localparam logic [CountW-1:0] CapacityReset  = 9'd256;

  typedef struct packed {
    logic             cmd;
    logic [ByteW-1:0] in_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              write_valid;
    logic [ByteW-1:0]  write_data;
    logic [ByteW-1:0]  write_index;
    logic [CountW-1:0] frame_length;
  } out_rsp_t;

  typedef struct packed {
    logic [ByteW-1:0]  delimiter_byte;
    logic [ByteW-1:0]  escape_byte;
    logic [ByteW-1:0]  escape_mask;
    logic [CountW-1:0] frame_capacity;
  } cfg_t;

endpackage

// ----- sv/byte_stuffing_frame_decoder_core.sv -----
// Top level of the byte stuffing frame decoder with request and result pipeline.
// A request accepted into the input register moves on to the output register
// as soon as that register is free.
// Throughput: one request per cycle; while a result waits, the input register holds
// one more request and then in_ready_o drops. Reset clears the decoder state, both
// pipeline valids and restores the register defaults; a reset command keeps the registers.
module byte_stuffing_frame_decoder_core
  import bsfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_rsp_t         out_rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int unsigned CapLimitInt = (MAX_FRAME < 256) ? MAX_FRAME : 256;
  localparam logic [CountW-1:0] CapLimit = CountW'(CapLimitInt);

  cfg_t cfg;

  bsfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic              in_valid_q;
  in_req_t           in_q;
  logic              out_valid_q;
  out_rsp_t          out_q;
  logic              receiving_q, receiving_d;
  logic              escape_q, escape_d;
  logic              overflow_q, overflow_d;
  logic [CountW-1:0] count_q, count_d;
  logic              advance;
  logic              step;
  logic [CountW-1:0] eff_cap;
  logic [ByteW-1:0]  data_byte;
  logic              store;
  out_rsp_t          rsp_d;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign eff_cap    = (cfg.frame_capacity > CapLimit) ? CapLimit : cfg.frame_capacity;

  always_comb begin
    receiving_d = receiving_q;
    escape_d    = escape_q;
    overflow_d  = overflow_q;
    count_d     = count_q;
    data_byte   = in_q.in_byte;
    store       = 1'b0;
    rsp_d       = '0;
    rsp_d.status = StatusBusy;
    if (in_q.cmd == CmdReset) begin
      receiving_d  = 1'b0;
      escape_d     = 1'b0;
      overflow_d   = 1'b0;
      count_d      = '0;
      rsp_d.status = StatusIdle;
    end else if (!receiving_q) begin
      if (in_q.in_byte == cfg.delimiter_byte) begin
        receiving_d = 1'b1;
        escape_d    = 1'b0;
        overflow_d  = 1'b0;
        count_d     = '0;
      end else begin
        rsp_d.status = StatusIdle;
      end
    end else if (overflow_q) begin
      if (in_q.in_byte == cfg.delimiter_byte) begin
        escape_d     = 1'b0;
        overflow_d   = 1'b0;
        count_d      = '0;
        rsp_d.status = StatusOverflow;
      end
    end else begin
      if (escape_q) begin
        escape_d  = 1'b0;
        data_byte = in_q.in_byte ^ cfg.escape_mask;
        store     = 1'b1;
      end else if (in_q.in_byte == cfg.escape_byte) begin
        escape_d = 1'b1;
      end else if (in_q.in_byte == cfg.delimiter_byte) begin
        receiving_d  = 1'b0;
        escape_d     = 1'b0;
        rsp_d.status = StatusComplete;
      end else begin
        store = 1'b1;
      end
      if (store) begin
        if (count_q >= eff_cap) begin
          count_d    = '0;
          escape_d   = 1'b0;
          overflow_d = 1'b1;
        end else begin
          rsp_d.write_valid = 1'b1;
          rsp_d.write_data  = data_byte;
          rsp_d.write_index = count_q[ByteW-1:0];
          count_d           = count_q + CountW'(1);
        end
      end
    end
    rsp_d.frame_length = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      receiving_q <= 1'b0;
      escape_q    <= 1'b0;
      overflow_q  <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        receiving_q <= receiving_d;
        escape_q    <= escape_d;
        overflow_q  <= overflow_d;
        count_q     <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
    if (step) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.write_valid |-> out_q.status == StatusBusy)
    else $error("Write reported outside an open frame.");

  a_write_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.write_valid |->
      out_q.frame_length == ({1'b0, out_q.write_index} + CountW'(1)))
    else $error("Frame length does not follow the write index.");

  a_overflow_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> count_q == '0 && receiving_q && !escape_q)
    else $error("Overflow state is inconsistent.");

  a_reset_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_q.cmd == CmdReset |=>
      out_q.status == StatusIdle && out_q.frame_length == '0 && !receiving_q)
    else $error("Reset request did not clear the decoder.");

  a_escape_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    escape_q |-> receiving_q)
    else $error("Escape pending outside a frame.");

endmodule

// ----- sv/bsfd_regs.sv -----
// APB configuration registers of the byte stuffing frame decoder.
module bsfd_regs
  import bsfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter_byte <= DelimiterReset;
      cfg_q.escape_byte    <= EscapeReset;
      cfg_q.escape_mask    <= MaskReset;
      cfg_q.frame_capacity <= CapacityReset;
    end else if (wr_en) begin
      case (reg_sel)
        RegDelimiter: cfg_q.delimiter_byte <= pwdata[ByteW-1:0];
        RegEscape:    cfg_q.escape_byte    <= pwdata[ByteW-1:0];
        RegMask:      cfg_q.escape_mask    <= pwdata[ByteW-1:0];
        RegCapacity:  cfg_q.frame_capacity <= pwdata[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      RegDelimiter: prdata = {{(DataW-ByteW){1'b0}}, cfg_q.delimiter_byte};
      RegEscape:    prdata = {{(DataW-ByteW){1'b0}}, cfg_q.escape_byte};
      RegMask:      prdata = {{(DataW-ByteW){1'b0}}, cfg_q.escape_mask};
      RegCapacity:  prdata = {{(DataW-CountW){1'b0}}, cfg_q.frame_capacity};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
